// ===== src/aopc_pkg.sv =====
// Shared types and constants for the alpha-over pixel compositor.
// Depends on nothing; used by the top level and its checker.
package aopc_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumChan  = 3;
  localparam int unsigned PixW     = 32;
  localparam int unsigned ColW     = ChanW * NumChan;
  localparam int unsigned ProdW    = 2 * ChanW;

  localparam logic [ChanW-1:0] FULL_WEIGHT  = 8'hFF;
  localparam logic [ChanW-1:0] ZERO_WEIGHT  = 8'h00;
  localparam logic [ChanW-1:0] OPAQUE_ALPHA = 8'hFF;
  localparam logic [PixW-1:0]  COLOR_MASK   = 32'hFFFF_FF00;

  localparam logic OP_SRC_OVER = 1'b0;
  localparam logic OP_COVERAGE = 1'b1;

  // Stage 1: operands selected, weight classified.
  typedef struct packed {
    logic [ColW-1:0]  col;
    logic [PixW-1:0]  dst;
    logic [ChanW-1:0] w;
    logic             w_zero;
    logic             w_full;
  } aopc_s1_t;

  // Stage 2: weighted channel sums.
  typedef struct packed {
    logic [NumChan-1:0][ProdW-1:0] sum;
    logic [ColW-1:0]               col;
    logic [PixW-1:0]               dst;
    logic                          w_zero;
    logic                          w_full;
  } aopc_s2_t;

endpackage

// ===== src/alpha_over_pixel_compositor_unit.sv =====
// Throughput: one word per cycle unless a low out_ready stalls the output.
// Stages: operand select, per-channel multiply-add, divide by 255 and result select.
// Each stage holds its word only while the next one is full and stalled.
// Synchronous active-low reset clears the stage valid bits and sets fill_color to 0.
// Depends on aopc_pkg for stage types and constants.
module alpha_over_pixel_compositor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_src_pixel,
  input  logic [31:0] in_dst_pixel,
  input  logic [7:0]  in_coverage,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel,
  output logic        out_write_enable,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0] fill_color_r;

  logic              v1_r, v2_r, v3_r;
  aopc_pkg::aopc_s1_t s1_r, s1_nxt;
  aopc_pkg::aopc_s2_t s2_r, s2_nxt;
  logic [31:0]       pix_r, pix_nxt;
  logic              we_r, we_nxt;

  logic rdy1, rdy2, rdy3;

  // A stage can take a word when empty or when its word moves on.
  assign rdy3 = !v3_r || out_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_ready  = rdy1;
  assign cfg_ready = 1'b1;

  assign out_valid        = v3_r;
  assign out_pixel        = pix_r;
  assign out_write_enable = we_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_color_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      fill_color_r <= cfg_data;
    end
  end

  // Stage 1: pick color and weight.
  always_comb begin
    if (in_op == aopc_pkg::OP_COVERAGE) begin
      s1_nxt.col = fill_color_r[31:8];
      s1_nxt.w   = in_coverage;
    end else begin
      s1_nxt.col = in_src_pixel[31:8];
      s1_nxt.w   = in_src_pixel[7:0];
    end
    s1_nxt.dst    = in_dst_pixel;
    s1_nxt.w_zero = (s1_nxt.w == aopc_pkg::ZERO_WEIGHT);
    s1_nxt.w_full = (s1_nxt.w == aopc_pkg::FULL_WEIGHT);
  end

  // Stage 2: c*w + d*(255-w) per channel, at most 65025.
  always_comb begin
    logic [7:0]  wi;
    logic [15:0] pc, pd;
    wi = aopc_pkg::FULL_WEIGHT - s1_r.w;
    s2_nxt.col    = s1_r.col;
    s2_nxt.dst    = s1_r.dst;
    s2_nxt.w_zero = s1_r.w_zero;
    s2_nxt.w_full = s1_r.w_full;
    for (int i = 0; i < aopc_pkg::NumChan; i++) begin
      pc = {8'd0, s1_r.col[i*8 +: 8]} * {8'd0, s1_r.w};
      pd = {8'd0, s1_r.dst[(i+1)*8 +: 8]} * {8'd0, wi};
      s2_nxt.sum[i] = pc + pd;
    end
  end

  // Stage 3: x/255 = (x + 1 + (x >> 8)) >> 8, exact for x below 65535.
  always_comb begin
    logic [16:0] t;
    logic [23:0] blend;
    for (int i = 0; i < aopc_pkg::NumChan; i++) begin
      t = {1'b0, s2_r.sum[i]} + 17'd1 + {9'd0, s2_r.sum[i][15:8]};
      blend[i*8 +: 8] = t[15:8];
    end
    priority if (s2_r.w_zero) begin
      pix_nxt = s2_r.dst;
      we_nxt  = 1'b0;
    end else if (s2_r.w_full) begin
      pix_nxt = ({s2_r.col, 8'd0} & aopc_pkg::COLOR_MASK) | {24'd0, aopc_pkg::OPAQUE_ALPHA};
      we_nxt  = 1'b1;
    end else begin
      pix_nxt = {blend, aopc_pkg::OPAQUE_ALPHA};
      we_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Payload advances with its valid bit; hold otherwise.
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1_r <= s1_nxt;
    if (rdy2 && v1_r)     s2_r <= s2_nxt;
    if (rdy3 && v2_r) begin
      pix_r <= pix_nxt;
      we_r  <= we_nxt;
    end
  end

endmodule

// ===== src/aopc_checker.sv =====
// Port-level checker for the alpha-over pixel compositor, with its bind.
// Depends on alpha_over_pixel_compositor_unit and aopc_pkg.
module aopc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel,
  input logic        out_write_enable
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Every written pixel is opaque.
  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_enable |-> out_pixel[7:0] == aopc_pkg::OPAQUE_ALPHA)
    else $error("written pixel not opaque");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel) && $stable(out_write_enable))
    else $error("output word changed while stalled");

endmodule

bind alpha_over_pixel_compositor_unit aopc_checker u_aopc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_pixel        (out_pixel),
  .out_write_enable (out_write_enable)
);

// ===== dv/tb.sv =====
// Testbench for alpha_over_pixel_compositor_unit: random and directed pixel words with checking.
// Depends on aopc_pkg and the compositor RTL; a small checker class predicts each result.
module tb;

  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned HoldCycles = 40;
  localparam int unsigned PhaseItems = 215;

  typedef struct packed {
    logic [aopc_pkg::PixW-1:0] pixel;
    logic                      we;
  } blend_result_t;

  class composite_checker;
    logic [aopc_pkg::PixW-1:0] fill_color = '0;
    blend_result_t             expected_pixels[$];
    int unsigned               mismatches = 0;
    int unsigned               n_checked = 0;
    int unsigned               n_skip = 0;
    int unsigned               n_full = 0;
    int unsigned               n_blend = 0;

    task report(string msg);
      mismatches++;
      if (mismatches <= 20) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Source over takes the source alpha; coverage mode takes the fill color.
    function blend_result_t blend_pixel(logic op, logic [aopc_pkg::PixW-1:0] src,
                                        logic [aopc_pkg::PixW-1:0] dst,
                                        logic [aopc_pkg::ChanW-1:0] cov);
      logic [aopc_pkg::PixW-1:0]  col;
      logic [aopc_pkg::ChanW-1:0] w;
      int unsigned                c;
      int unsigned                d;
      blend_result_t              r;
      if (op == aopc_pkg::OP_SRC_OVER) begin
        col = src;
        w = src[aopc_pkg::ChanW-1:0];
      end else begin
        col = fill_color;
        w = cov;
      end
      if (w == aopc_pkg::ZERO_WEIGHT) begin
        r.pixel = dst;
        r.we = 1'b0;
        n_skip++;
      end else if (w == aopc_pkg::FULL_WEIGHT) begin
        r.pixel = (col & aopc_pkg::COLOR_MASK) | 32'(aopc_pkg::OPAQUE_ALPHA);
        r.we = 1'b1;
        n_full++;
      end else begin
        for (int ch = 1; ch <= aopc_pkg::NumChan; ch++) begin
          c = col[ch*aopc_pkg::ChanW +: aopc_pkg::ChanW];
          d = dst[ch*aopc_pkg::ChanW +: aopc_pkg::ChanW];
          r.pixel[ch*aopc_pkg::ChanW +: aopc_pkg::ChanW] =
            8'((c * 32'(w) + d * (32'(aopc_pkg::FULL_WEIGHT) - 32'(w)))
               / 32'(aopc_pkg::FULL_WEIGHT));
        end
        r.pixel[aopc_pkg::ChanW-1:0] = aopc_pkg::OPAQUE_ALPHA;
        r.we = 1'b1;
        n_blend++;
      end
      return r;
    endfunction

    function void note_pixel(logic op, logic [aopc_pkg::PixW-1:0] src,
                             logic [aopc_pkg::PixW-1:0] dst,
                             logic [aopc_pkg::ChanW-1:0] cov);
      expected_pixels.push_back(blend_pixel(op, src, dst, cov));
    endfunction

    task check_pixel(logic [aopc_pkg::PixW-1:0] pixel, logic we);
      blend_result_t e;
      if (expected_pixels.size() == 0) begin
        report($sformatf("result word with none expected: pixel %08h we %0b", pixel, we));
      end else begin
        e = expected_pixels.pop_front();
        n_checked++;
        if (pixel !== e.pixel)
          report($sformatf("out_pixel %08h, expected %08h", pixel, e.pixel));
        if (we !== e.we)
          report($sformatf("out_write_enable %0b, expected %0b", we, e.we));
      end
    endtask

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [31:0] in_src_pixel;
  logic [31:0] in_dst_pixel;
  logic [7:0]  in_coverage;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_pixel;
  logic        out_write_enable;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  composite_checker comp_chk = new();
  int unsigned      quiet_cycles = 0;
  int unsigned      fill_writes = 0;
  bit               steady = 1'b0;
  bit               hold_req = 1'b0;

  alpha_over_pixel_compositor_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_src_pixel     (in_src_pixel),
    .in_dst_pixel     (in_dst_pixel),
    .in_coverage      (in_coverage),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel        (out_pixel),
    .out_write_enable (out_write_enable),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample every handshake at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        comp_chk.note_pixel(in_op, in_src_pixel, in_dst_pixel, in_coverage);
      if (out_valid && out_ready)
        comp_chk.check_pixel(out_pixel, out_write_enable);
      if (cfg_valid && cfg_ready)
        comp_chk.fill_color = cfg_data;
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    do @(negedge clk); while (quiet_cycles < QuietLimit);
    $display("timeout: no word moved for %0d cycles", QuietLimit);
    $display("** alpha_over_pixel_compositor_unit: FAILED **");
    $finish;
  end

  // Result side: random stalls, steady stretches and one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (int k = 1; k < HoldCycles; k++) @(negedge clk);
        hold_req = 1'b0;
      end else if (steady || !rst_n) begin
        out_ready <= rst_n;
      end else begin
        out_ready <= ($urandom_range(99) >= 26);
      end
    end
  end

  task automatic send_pixel(logic op, logic [31:0] src, logic [31:0] dst, logic [7:0] cov);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_op        <= op;
    in_src_pixel <= src;
    in_dst_pixel <= dst;
    in_coverage  <= cov;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_gap();
    if (!steady && $urandom_range(99) < 26) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (comp_chk.pending() != 0) @(negedge clk);
  endtask

  // Write only with the pipe empty.
  task automatic write_fill(logic [31:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    fill_writes++;
  endtask

  function automatic logic [7:0] pick_weight();
    case ($urandom_range(9))
      0, 1:    return aopc_pkg::ZERO_WEIGHT;
      2, 3:    return aopc_pkg::FULL_WEIGHT;
      4:       return 8'h01;
      5:       return 8'hFE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random();
    logic        op;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  cov;
    logic [7:0]  w;
    op  = $urandom_range(1) ? aopc_pkg::OP_COVERAGE : aopc_pkg::OP_SRC_OVER;
    src = $urandom;
    dst = $urandom;
    cov = 8'($urandom_range(255));
    w   = pick_weight();
    if (op == aopc_pkg::OP_SRC_OVER) src[7:0] = w;
    else cov = w;
    send_pixel(op, src, dst, cov);
    idle_gap();
  endtask

  initial begin
    logic [31:0] phase_fill[6];
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_op        = aopc_pkg::OP_SRC_OVER;
    in_src_pixel = '0;
    in_dst_pixel = '0;
    in_coverage  = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Fill color still at its reset value here.
    send_pixel(aopc_pkg::OP_SRC_OVER, 32'hFFFF_FF00, 32'h1234_5678, 8'hFF);
    send_pixel(aopc_pkg::OP_SRC_OVER, 32'h0000_00FF, 32'hFFFF_FFFF, 8'h00);
    send_pixel(aopc_pkg::OP_SRC_OVER, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00);
    send_pixel(aopc_pkg::OP_SRC_OVER, 32'hFFFF_FF01, 32'h0000_0000, 8'h80);
    send_pixel(aopc_pkg::OP_SRC_OVER, 32'h0000_00FE, 32'hFFFF_FFFF, 8'hFF);
    send_pixel(aopc_pkg::OP_SRC_OVER, 32'hFF00_FF80, 32'h00FF_00AA, 8'h00);
    send_pixel(aopc_pkg::OP_SRC_OVER, 32'hFFFF_FF7F, 32'hFFFF_FF00, 8'h01);
    send_pixel(aopc_pkg::OP_COVERAGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h80);
    send_pixel(aopc_pkg::OP_COVERAGE, 32'hFFFF_FFFF, 32'h89AB_CDEF, 8'h00);
    send_pixel(aopc_pkg::OP_COVERAGE, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF);
    write_fill(32'hFFFF_FFFF);
    send_pixel(aopc_pkg::OP_COVERAGE, 32'h0000_0000, 32'h0000_0000, 8'hFF);
    send_pixel(aopc_pkg::OP_COVERAGE, 32'h0000_0000, 32'h0000_0000, 8'h01);
    send_pixel(aopc_pkg::OP_COVERAGE, 32'hFFFF_FFFF, 32'h0000_0000, 8'hFE);
    send_pixel(aopc_pkg::OP_COVERAGE, 32'h0000_0000, 32'h1234_5600, 8'h80);
    send_pixel(aopc_pkg::OP_COVERAGE, 32'hFFFF_FF7F, 32'h0000_0000, 8'h00);

    phase_fill[0] = 32'h0000_00FF;
    phase_fill[1] = $urandom;
    phase_fill[2] = 32'hFFFF_FF00;
    phase_fill[3] = $urandom;
    phase_fill[4] = 32'h0000_0000;
    phase_fill[5] = $urandom;
    for (int ph = 0; ph < 6; ph++) begin
      write_fill(phase_fill[ph]);
      steady = (ph == 3);
      for (int i = 0; i < PhaseItems; i++) begin
        // Stall the result side while words keep coming, so the pipe backs up.
        if (ph == 1 && i == 40) hold_req = 1'b1;
        if (ph == 2 && i == 100) wait_drained();
        send_random();
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (8) @(negedge clk);
    if (comp_chk.pending() != 0)
      comp_chk.report($sformatf("%0d expected words never arrived", comp_chk.pending()));
    $display("checked %0d result words over %0d fill color writes", comp_chk.n_checked,
             fill_writes);
    $display("no-write %0d, full-weight %0d, blended %0d; %0d mismatches", comp_chk.n_skip,
             comp_chk.n_full, comp_chk.n_blend, comp_chk.mismatches);
    if (comp_chk.mismatches == 0) begin
      $display("** alpha_over_pixel_compositor_unit: PASSED **");
    end else begin
      $display("** alpha_over_pixel_compositor_unit: FAILED **");
    end
    $finish;
  end

endmodule
